FILE: hdl/ismu_pkg.sv
`default_nettype none

package ismu_pkg;

   localparam int SIDE   = 16;
   localparam int CW     = $clog2(SIDE);
   localparam int CELLS  = SIDE * SIDE * SIDE;
   localparam int AW     = 3 * CW;

   localparam int IN_CW  = 4;
   localparam int THR_W  = 16;
   localparam int DE_W   = 6;
   localparam int E_W    = 15;
   localparam int M_W    = 14;
   localparam int CSR_IW = 2;
   localparam int STEP_W = 3;

   localparam logic [E_W-1:0] ENERGY_RST = E_W'(-3 * CELLS);
   localparam logic [M_W-1:0] MAG_RST    = M_W'(-CELLS);

   // read order: the site itself, then its six neighbours
   localparam logic [STEP_W-1:0] STEP_SITE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_XP   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_XM   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_YP   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_YM   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ZP   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_ZM   = 3'd6;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

   localparam logic [CSR_IW-1:0] CSR_THR4  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_THR8  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_THR12 = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TRIAL = 1'b1;

   typedef struct packed {
      logic start;
      logic site_vld;
      logic nb_vld;
      logic commit;
   } ctl_type;

endpackage

`default_nettype wire

FILE: hdl/ismu_ram.sv
`default_nettype none

module ismu_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/ismu_addr.sv
`default_nettype none

module ismu_addr (
   input  wire logic [ismu_pkg::CW-1:0]     x,
   input  wire logic [ismu_pkg::CW-1:0]     y,
   input  wire logic [ismu_pkg::CW-1:0]     z,
   input  wire logic [ismu_pkg::STEP_W-1:0] step,
   output logic      [ismu_pkg::AW-1:0]     addr
);

   import ismu_pkg::*;

   logic [CW-1:0] xs;
   logic [CW-1:0] ys;
   logic [CW-1:0] zs;

   // periodic wrap falls out of the CW-bit add
   always_comb begin
      xs = x;
      ys = y;
      zs = z;
      unique case (step)
         STEP_XP: xs = x + CW'(1);
         STEP_XM: xs = x - CW'(1);
         STEP_YP: ys = y + CW'(1);
         STEP_YM: ys = y - CW'(1);
         STEP_ZP: zs = z + CW'(1);
         STEP_ZM: zs = z - CW'(1);
         default: ;
      endcase
   end

   assign addr = {xs, ys, zs};

endmodule

`default_nettype wire

FILE: hdl/ismu_eval.sv
`default_nettype none

module ismu_eval (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ismu_pkg::ctl_type              ctl,
   input  wire logic                           rd_bit,
   input  wire logic                           op,
   input  wire logic                           spin_value,
   input  wire logic [ismu_pkg::THR_W-1:0]     rand_fraction,
   input  wire logic [ismu_pkg::THR_W-1:0]     thr4,
   input  wire logic [ismu_pkg::THR_W-1:0]     thr8,
   input  wire logic [ismu_pkg::THR_W-1:0]     thr12,
   output logic                                change,
   output logic                                site_spin,
   output logic                                flipped,
   output logic                                spin_after,
   output logic signed [ismu_pkg::DE_W-1:0]    energy_change,
   output logic signed [ismu_pkg::E_W-1:0]     energy_total,
   output logic signed [ismu_pkg::M_W-1:0]     magnetization_total
);

   import ismu_pkg::*;

   // aligned neighbour count m gives dH = 4m - 12
   logic [2:0]        m_ff;
   logic [2:0]        m_in;
   logic              site_ff;
   logic              site_in;
   logic [E_W-1:0]    energy_ff;
   logic [E_W-1:0]    energy_in;
   logic [M_W-1:0]    mag_ff;
   logic [M_W-1:0]    mag_in;
   logic              flip_ff;
   logic              spin_ff;
   logic [DE_W-1:0]   de_ff;
   logic [E_W-1:0]    etot_ff;
   logic [M_W-1:0]    mtot_ff;
   logic [DE_W-1:0]   dh;
   logic [DE_W-1:0]   de;
   logic              trial_ok;

   always_comb begin
      m_in = m_ff;
      if (ctl.start) begin
         m_in = '0;
      end else if (ctl.nb_vld) begin
         m_in = m_ff + {2'b00, rd_bit == site_ff};
      end
   end

   assign site_in = ctl.site_vld ? rd_bit : site_ff;

   assign dh = DE_W'({1'b0, m_ff, 2'b00}) - DE_W'(12);

   always_comb begin
      case (m_ff)
         3'd4:    trial_ok = rand_fraction < thr4;
         3'd5:    trial_ok = rand_fraction < thr8;
         3'd6:    trial_ok = rand_fraction < thr12;
         default: trial_ok = 1'b1;
      endcase
   end

   assign change = (op == OP_TRIAL) ? trial_ok : (spin_value != site_ff);
   assign de     = change ? dh : '0;

   always_comb begin
      energy_in = energy_ff;
      mag_in    = mag_ff;
      if (ctl.commit && change) begin
         energy_in = energy_ff + {{(E_W - DE_W){dh[DE_W-1]}}, dh};
         mag_in    = site_ff ? mag_ff - M_W'(2) : mag_ff + M_W'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff      <= '0;
         site_ff   <= 1'b0;
         energy_ff <= ENERGY_RST;
         mag_ff    <= MAG_RST;
      end else begin
         m_ff      <= m_in;
         site_ff   <= site_in;
         energy_ff <= energy_in;
         mag_ff    <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         flip_ff <= (op == OP_TRIAL) && change;
         spin_ff <= site_ff ^ change;
         de_ff   <= de;
         etot_ff <= energy_in;
         mtot_ff <= mag_in;
      end
   end

   assign site_spin           = site_ff;
   assign flipped             = flip_ff;
   assign spin_after          = spin_ff;
   assign energy_change       = $signed(de_ff);
   assign energy_total        = $signed(etot_ff);
   assign magnetization_total = $signed(mtot_ff);

endmodule

`default_nettype wire

FILE: hdl/ising_metropolis_site_update.sv
// Sequence per item: accept, seven reads on the single-port lattice RAM plus a
//   wait for the registered read data, then the write if the spin changes; a new
//   item is taken only back in idle, and the commit stalls while a result beat waits.
// Reset: synchronous; afterwards a clearing pass writes every spin down,
//   with req_ready low; configuration writes are taken meanwhile.
`default_nettype none

module ising_metropolis_site_update (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_op,
   input  wire logic [ismu_pkg::IN_CW-1:0]         req_site_x,
   input  wire logic [ismu_pkg::IN_CW-1:0]         req_site_y,
   input  wire logic [ismu_pkg::IN_CW-1:0]         req_site_z,
   input  wire logic                               req_spin_value,
   input  wire logic [ismu_pkg::THR_W-1:0]         req_rand_fraction,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_flipped,
   output logic                                    rsp_spin_after,
   output logic signed [ismu_pkg::DE_W-1:0]        rsp_energy_change,
   output logic signed [ismu_pkg::E_W-1:0]         rsp_energy_total,
   output logic signed [ismu_pkg::M_W-1:0]         rsp_magnetization_total,
   input  wire logic                               csr_we,
   input  wire logic [ismu_pkg::CSR_IW-1:0]        csr_index,
   input  wire logic [ismu_pkg::THR_W-1:0]         csr_wdata
);

   import ismu_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]        st_ff;
   logic [1:0]        st_in;
   logic [STEP_W-1:0] cnt_ff;
   logic [STEP_W-1:0] cnt_in;
   logic [AW-1:0]     clr_ff;
   logic [AW-1:0]     clr_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic [THR_W-1:0]  thr4_ff;
   logic [THR_W-1:0]  thr8_ff;
   logic [THR_W-1:0]  thr12_ff;

   logic              op_ff;
   logic [CW-1:0]     x_ff;
   logic [CW-1:0]     y_ff;
   logic [CW-1:0]     z_ff;
   logic              spv_ff;
   logic [THR_W-1:0]  rnd_ff;

   logic              accept;
   logic              commit;
   logic              change;
   logic              site_spin;
   logic              rd_bit;
   logic              ram_we;
   logic              ram_wdata;
   logic [AW-1:0]     ram_addr;
   logic [AW-1:0]     gen_addr;
   logic [STEP_W-1:0] step;
   ctl_type           ctl;

   assign req_ready = (st_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (st_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      clr_in = clr_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = STEP_SITE;
            if (accept) begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            if (cnt_ff == STEP_LAST) begin
               st_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_FIN: begin
            if (commit) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         cnt_ff       <= STEP_SITE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         thr4_ff      <= '0;
         thr8_ff      <= '0;
         thr12_ff     <= '0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_THR4:  thr4_ff  <= csr_wdata;
               CSR_THR8:  thr8_ff  <= csr_wdata;
               CSR_THR12: thr12_ff <= csr_wdata;
               default:   ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         x_ff   <= CW'(req_site_x % SIDE);
         y_ff   <= CW'(req_site_y % SIDE);
         z_ff   <= CW'(req_site_z % SIDE);
         spv_ff <= req_spin_value;
         rnd_ff <= req_rand_fraction;
      end
   end

   // the RAM read is registered, so read data shows up in the beat after its address
   assign ctl.start    = accept;
   assign ctl.site_vld = (st_ff == ST_READ) && (cnt_ff == STEP_XP);
   assign ctl.nb_vld   = (st_ff == ST_READ) && (cnt_ff > STEP_XP);
   assign ctl.commit   = commit;

   assign step = (st_ff == ST_READ) ? cnt_ff : STEP_SITE;

   ismu_addr u_addr (
      .x    (x_ff),
      .y    (y_ff),
      .z    (z_ff),
      .step (step),
      .addr (gen_addr)
   );

   assign ram_addr  = (st_ff == ST_CLEAR) ? clr_ff : gen_addr;
   assign ram_we    = (st_ff == ST_CLEAR) || (commit && change);
   assign ram_wdata = (st_ff == ST_CLEAR) ? 1'b0 : ~site_spin;

   ismu_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_lattice (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (rd_bit)
   );

   ismu_eval u_eval (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .rd_bit              (rd_bit),
      .op                  (op_ff),
      .spin_value          (spv_ff),
      .rand_fraction       (rnd_ff),
      .thr4                (thr4_ff),
      .thr8                (thr8_ff),
      .thr12               (thr12_ff),
      .change              (change),
      .site_spin           (site_spin),
      .flipped             (rsp_flipped),
      .spin_after          (rsp_spin_after),
      .energy_change       (rsp_energy_change),
      .energy_total        (rsp_energy_total),
      .magnetization_total (rsp_magnetization_total)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/ismu_checker.sv
`default_nettype none

module ismu_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic                               rsp_flipped,
   input  wire logic                               rsp_spin_after,
   input  wire logic signed [ismu_pkg::DE_W-1:0]   rsp_energy_change,
   input  wire logic signed [ismu_pkg::E_W-1:0]    rsp_energy_total,
   input  wire logic signed [ismu_pkg::M_W-1:0]    rsp_magnetization_total
);

   // no result may appear straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("result or ready straight after reset");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready again right after an accepted beat");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_energy_total)
         && $stable(rsp_magnetization_total) && $stable(rsp_spin_after)
         && $stable(rsp_flipped))
      else $error("result beat changed while stalled");

   // energy steps are multiples of four; an even cell count keeps M even
   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_energy_change[1:0] == 2'b00)
         && (rsp_magnetization_total[0] == 1'b0))
      else $error("energy step or magnetization parity broken");

endmodule

bind ising_metropolis_site_update ismu_checker u_ismu_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_valid),
   .req_ready               (req_ready),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_flipped             (rsp_flipped),
   .rsp_spin_after          (rsp_spin_after),
   .rsp_energy_change       (rsp_energy_change),
   .rsp_energy_total        (rsp_energy_total),
   .rsp_magnetization_total (rsp_magnetization_total)
);

`default_nettype wire
